FILE: hw/rtl/rts_pkg.sv
// Shared types, constants and the angle table function for the right triangle solver.
`timescale 1ns / 1ps
`default_nettype none

package rts_pkg;

  localparam int ANG_FRAC   = 48;
  localparam int SQRT_STEPS = 33;
  localparam int QUOT_STEPS = 33;

  localparam logic [32:0] MAX_C = 33'h1_FFFF_FFFF;
  localparam logic [31:0] MAX_B = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_ZERO  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Values carried beside the datapath of every stage.
  typedef struct packed {
    logic        mode;
    logic [31:0] a;
    logic [31:0] second;
    logic [31:0] alpha;
    logic        x_pos;
    logic        y_pos;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [32:0] root;
    logic        ov_c;
    logic        ov_b;
  } side_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec_t;

  typedef struct packed {
    logic [65:0] rad;
    logic [32:0] root;
    logic [35:0] rem;
  } root_t;

  typedef struct packed {
    logic [32:0] nc;
    logic [32:0] nb;
    logic [31:0] rc;
    logic [31:0] rb;
    logic [32:0] qc;
    logic [32:0] qb;
  } quot_t;

  // Shift-subtract division, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_series(input logic [63:0] p_in, input logic [63:0] sq);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] dd;
    logic [63:0] t;
    logic        sub;
    p   = p_in;
    sum = '0;
    dd  = 64'd1;
    sub = 1'b0;
    for (int n = 0; n < 64; n++) begin
      if (p != '0) begin
        t   = udiv64(p, dd);
        sum = sub ? sum - t : sum + t;
        sub = !sub;
        dd  = dd + 64'd2;
        p   = udiv64(p, sq);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] ratio48(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int k = 0; k < ANG_FRAC; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, signed Q48.
  function automatic logic signed [63:0] deg_angle(input int i);
    logic [63:0] one;
    logic [63:0] quarter;
    logic [63:0] v;
    one     = 64'd1 << 62;
    quarter = 64'd4 * atan_series(udiv64(one, 64'd5), 64'd25)
              - atan_series(udiv64(one, 64'd239), 64'd57121);
    if (i < 31) begin
      v = atan_series(64'd1 << (62 - i), 64'd1 << (2 * i));
    end else if (i <= 62) begin
      v = 64'd1 << (62 - i);
    end else begin
      v = '0;
    end
    if (i == 0) begin
      return $signed(64'd45 << ANG_FRAC);
    end
    return $signed(64'd45 * ratio48(v, quarter));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/right_triangle_solver.sv
// Top level of the pipelined right triangle solver.
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined: 2 input stages, one CORDIC cell per rotation step, 2 post
// stages, 33 square-root cells, 2 multiply stages, 33 divider cells and 1
// output register. One request is accepted every cycle unless a result waits
// at the output; the whole chain holds while a result waits there, so s_tready
// follows m_tready and the output valid.

module right_triangle_solver #(
  parameter int FRACTION_BITS  = 16,
  parameter int ROTATION_STEPS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [63:0]   s_tdata,  // side_a[31:0], second_value[63:32]
  input  wire logic          s_tuser,  // mode
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [119:0]       m_tdata   // hypotenuse[32:0], side_b_out[64:33],
                                       // alpha_degrees[87:65], beta_degrees[110:88],
                                       // status[112:111], zero pad
);

  localparam logic [31:0] NINETY = 32'(90 << FRACTION_BITS);
  localparam int          RND_SH = rts_pkg::ANG_FRAC - FRACTION_BITS;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // CORDIC chain
  logic           cv    [0:ROTATION_STEPS];
  rts_pkg::vec_t  cvec  [0:ROTATION_STEPS];
  rts_pkg::side_t cside [0:ROTATION_STEPS];

  rts_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .mode     (s_tuser),
    .a        (s_tdata[31:0]),
    .second   (s_tdata[63:32]),
    .out_valid(cv[0]),
    .out_vec  (cvec[0]),
    .out_side (cside[0])
  );

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cordic
    rts_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (cv[i]),
      .in_vec   (cvec[i]),
      .in_side  (cside[i]),
      .out_valid(cv[i+1]),
      .out_vec  (cvec[i+1]),
      .out_side (cside[i+1])
    );
  end

  // Post stage 1: angle rounding, magnitudes, squares
  rts_pkg::vec_t  cend;
  rts_pkg::side_t send;
  logic [63:0]    zu;
  logic [63:0]    zr;
  logic [63:0]    xa;
  logic [31:0]    mp;
  logic [31:0]    mq;
  logic [63:0]    sqp;
  logic [63:0]    sqq;
  rts_pkg::side_t p1_side_next;
  logic           p1_valid;
  rts_pkg::side_t p1_side;
  logic [63:0]    p1_sqp;
  logic [63:0]    p1_sqq;

  always_comb begin
    cend = cvec[ROTATION_STEPS];
    send = cside[ROTATION_STEPS];
    zu   = cend.z[63] ? 64'd0 : 64'(cend.z);
    zr   = (zu + (64'd1 << (RND_SH - 1))) >> RND_SH;
    xa   = cend.x[63] ? 64'(-cend.x) : 64'(cend.x);
    mp   = send.mode ? xa[31:0] : send.a;
    mq   = send.mode ? cend.y[31:0] : send.second;
    sqp  = mp * mp;
    sqq  = mq * mq;
    p1_side_next       = send;
    p1_side_next.alpha = (zr > 64'(NINETY)) ? NINETY : zr[31:0];
    p1_side_next.x_pos = cend.x > 0;
    p1_side_next.y_pos = cend.y > 0;
    p1_side_next.ux    = xa[31:0];
    p1_side_next.uy    = cend.y[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= cv[ROTATION_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side <= p1_side_next;
      p1_sqp  <= sqp;
      p1_sqq  <= sqq;
    end
  end

  // Post stage 2: radicand, then the square-root chain
  logic           sv    [0:rts_pkg::SQRT_STEPS];
  rts_pkg::root_t sroot [0:rts_pkg::SQRT_STEPS];
  rts_pkg::side_t sside [0:rts_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sroot[0] <= '{rad: 66'(p1_sqp) + 66'(p1_sqq), root: '0, rem: '0};
      sside[0] <= p1_side;
    end
  end

  for (genvar j = 0; j < rts_pkg::SQRT_STEPS; j++) begin : g_sqrt
    rts_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (sv[j]),
      .in_root  (sroot[j]),
      .in_side  (sside[j]),
      .out_valid(sv[j+1]),
      .out_root (sroot[j+1]),
      .out_side (sside[j+1])
    );
  end

  // Multiply stage 1: round the root, form products
  rts_pkg::root_t rend;
  logic [32:0]    rr;
  rts_pkg::side_t m1_side_next;
  logic           m1_valid;
  rts_pkg::side_t m1_side;
  logic [64:0]    m1_mc;
  logic [63:0]    m1_mb;

  always_comb begin
    rend = sroot[rts_pkg::SQRT_STEPS];
    rr   = rend.root + 33'((rend.rem > {3'd0, rend.root}) ? 1 : 0);
    m1_side_next      = sside[rts_pkg::SQRT_STEPS];
    m1_side_next.root = rr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= sv[rts_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_side <= m1_side_next;
      m1_mc   <= sside[rts_pkg::SQRT_STEPS].a * rr;
      m1_mb   <= sside[rts_pkg::SQRT_STEPS].a * sside[rts_pkg::SQRT_STEPS].ux;
    end
  end

  // Multiply stage 2: add half divisor, check for quotient overflow
  logic [65:0]    nc;
  logic [65:0]    nb;
  rts_pkg::side_t d_side_next;
  logic           dq_v  [0:rts_pkg::QUOT_STEPS];
  rts_pkg::quot_t dquot [0:rts_pkg::QUOT_STEPS];
  rts_pkg::side_t dside [0:rts_pkg::QUOT_STEPS];

  always_comb begin
    nc = 66'(m1_mc) + 66'(m1_side.uy >> 1);
    nb = 66'(m1_mb) + 66'(m1_side.uy >> 1);
    d_side_next      = m1_side;
    d_side_next.ov_c = nc[65:33] >= 33'(m1_side.uy);
    d_side_next.ov_b = nb[65:33] >= 33'(m1_side.uy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_v[0] <= 1'b0;
    end else if (adv) begin
      dq_v[0] <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= d_side_next;
      dquot[0] <= '{nc: nc[32:0], nb: nb[32:0], rc: nc[64:33], rb: nb[64:33],
                    qc: '0, qb: '0};
    end
  end

  for (genvar k = 0; k < rts_pkg::QUOT_STEPS; k++) begin : g_div
    rts_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (dq_v[k]),
      .in_quot  (dquot[k]),
      .in_side  (dside[k]),
      .out_valid(dq_v[k+1]),
      .out_quot (dquot[k+1]),
      .out_side (dside[k+1])
    );
  end

  // Result selection
  rts_pkg::side_t  fs;
  rts_pkg::quot_t  fq;
  logic [32:0]     res_c;
  logic [31:0]     res_b;
  logic [31:0]     res_alpha;
  logic [31:0]     res_beta;
  rts_pkg::status_t res_st;
  logic            b_sat;

  always_comb begin
    fs        = dside[rts_pkg::QUOT_STEPS];
    fq        = dquot[rts_pkg::QUOT_STEPS];
    b_sat     = fs.ov_b || fq.qb[32];
    res_c     = '0;
    res_b     = '0;
    res_alpha = '0;
    res_st    = rts_pkg::ST_OK;
    if (!fs.mode) begin
      res_c = fs.root;
      res_b = fs.second;
      if (fs.a == '0 && fs.second == '0) begin
        res_st = rts_pkg::ST_ZERO;
      end else if (fs.a == '0) begin
        res_alpha = '0;
      end else if (fs.second == '0) begin
        res_alpha = NINETY;
      end else begin
        res_alpha = fs.alpha;
      end
    end else if (fs.second > NINETY) begin
      res_alpha = NINETY;
      res_st    = rts_pkg::ST_RANGE;
    end else begin
      res_alpha = fs.second;
      if (fs.second == '0 || !fs.y_pos) begin
        res_c  = rts_pkg::MAX_C;
        res_b  = rts_pkg::MAX_B;
        res_st = rts_pkg::ST_SAT;
      end else begin
        res_c = fs.ov_c ? rts_pkg::MAX_C : fq.qc;
        if (fs.x_pos) begin
          res_b = b_sat ? rts_pkg::MAX_B : fq.qb[31:0];
        end
        if (fs.ov_c || (fs.x_pos && b_sat)) begin
          res_st = rts_pkg::ST_SAT;
        end
      end
    end
    res_beta = NINETY - res_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dq_v[rts_pkg::QUOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {7'd0, res_st, res_beta[22:0], res_alpha[22:0], res_b, res_c};
    end
  end

  // Checks
  a_zero_legs : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[112:111] == rts_pkg::ST_ZERO |-> m_tdata[64:0] == '0)
    else $error("both-legs-zero result carries nonzero lengths");

  a_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[112:111] == rts_pkg::ST_RANGE
      |-> m_tdata[32:0] == '0 && m_tdata[110:88] == '0)
    else $error("out-of-range angle result carries nonzero hypotenuse or beta");

  a_post_adv : assert property (@(posedge clk) disable iff (rst)
    adv && cv[ROTATION_STEPS] |=> p1_valid)
    else $error("request lost leaving the rotation chain");

  a_out_adv : assert property (@(posedge clk) disable iff (rst)
    adv && dq_v[rts_pkg::QUOT_STEPS] |=> m_tvalid)
    else $error("request lost leaving the divider chain");

endmodule

`default_nettype wire

FILE: hw/rtl/rts_front.sv
// Input stages: leg normalization and CORDIC start vector.
`timescale 1ns / 1ps
`default_nettype none

module rts_front #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire logic          mode,
  input  wire logic [31:0]   a,
  input  wire logic [31:0]   second,
  output logic               out_valid,
  output rts_pkg::vec_t      out_vec,
  output rts_pkg::side_t     out_side
);

  logic        v1;
  logic        mode1;
  logic [31:0] a1;
  logic [31:0] second1;
  logic [5:0]  shift1;
  logic [31:0] m;
  logic [4:0]  msb;

  always_comb begin
    m   = (a > second) ? a : second;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1   <= mode;
      a1      <= a;
      second1 <= second;
      // put the larger leg's top bit at bit 59
      shift1  <= 6'd59 - {1'b0, msb};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mode1) begin
        out_vec <= '{x: $signed(64'd1 << 31), y: '0,
                     z: $signed(64'(second1) << (rts_pkg::ANG_FRAC - FRACTION_BITS))};
      end else begin
        out_vec <= '{x: $signed(64'(second1) << shift1), y: $signed(64'(a1) << shift1),
                     z: '0};
      end
      out_side <= '{mode: mode1, a: a1, second: second1, default: '0};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rts_cordic_cell.sv
// One CORDIC micro-rotation, vectoring in leg mode and rotating in angle mode.
`timescale 1ns / 1ps
`default_nettype none

module rts_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire rts_pkg::vec_t  in_vec,
  input  wire rts_pkg::side_t in_side,
  output logic               out_valid,
  output rts_pkg::vec_t      out_vec,
  output rts_pkg::side_t     out_side
);

  localparam logic signed [63:0] ANGLE = rts_pkg::deg_angle(STEP);

  logic signed [63:0] xs;
  logic signed [63:0] ys;
  logic               pos;
  rts_pkg::vec_t      nxt;

  always_comb begin
    xs  = in_vec.x >>> STEP;
    ys  = in_vec.y >>> STEP;
    // angle mode steers by residual angle, leg mode drives y toward zero
    pos = in_side.mode ? !in_vec.z[63] : !(in_vec.y > 0);
    if (pos) begin
      nxt.x = in_vec.x - ys;
      nxt.y = in_vec.y + xs;
      nxt.z = in_vec.z - ANGLE;
    end else begin
      nxt.x = in_vec.x + ys;
      nxt.y = in_vec.y - xs;
      nxt.z = in_vec.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vec  <= nxt;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rts_sqrt_cell.sv
// One bit of a restoring square root over a 66-bit radicand.
`timescale 1ns / 1ps
`default_nettype none

module rts_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire rts_pkg::root_t in_root,
  input  wire rts_pkg::side_t in_side,
  output logic               out_valid,
  output rts_pkg::root_t     out_root,
  output rts_pkg::side_t     out_side
);

  logic [35:0]    rem2;
  logic [35:0]    trial;
  rts_pkg::root_t nxt;

  always_comb begin
    rem2    = {in_root.rem[33:0], in_root.rad[65:64]};
    trial   = {1'b0, in_root.root, 2'b01};
    nxt.rad = in_root.rad << 2;
    if (rem2 >= trial) begin
      nxt.rem  = rem2 - trial;
      nxt.root = {in_root.root[31:0], 1'b1};
    end else begin
      nxt.rem  = rem2;
      nxt.root = {in_root.root[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_root <= nxt;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rts_div_cell.sv
// One quotient bit for both divisions by the rotated sine.
`timescale 1ns / 1ps
`default_nettype none

module rts_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire rts_pkg::quot_t in_quot,
  input  wire rts_pkg::side_t in_side,
  output logic               out_valid,
  output rts_pkg::quot_t     out_quot,
  output rts_pkg::side_t     out_side
);

  logic [32:0]    rc2;
  logic [32:0]    rb2;
  logic [32:0]    dv;
  rts_pkg::quot_t nxt;

  always_comb begin
    dv     = {1'b0, in_side.uy};
    rc2    = {in_quot.rc, in_quot.nc[32]};
    rb2    = {in_quot.rb, in_quot.nb[32]};
    nxt.nc = in_quot.nc << 1;
    nxt.nb = in_quot.nb << 1;
    if (rc2 >= dv) begin
      nxt.rc = 32'(rc2 - dv);
      nxt.qc = {in_quot.qc[31:0], 1'b1};
    end else begin
      nxt.rc = rc2[31:0];
      nxt.qc = {in_quot.qc[31:0], 1'b0};
    end
    if (rb2 >= dv) begin
      nxt.rb = 32'(rb2 - dv);
      nxt.qb = {in_quot.qb[31:0], 1'b1};
    end else begin
      nxt.rb = rb2[31:0];
      nxt.qb = {in_quot.qb[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_quot <= nxt;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

FILE: tb/right_triangle_solver_checker.sv
// Checker for the right triangle solver: predicts each result and compares it on the output stream.
`timescale 1ns / 1ps
`default_nettype none

module right_triangle_solver_checker #(
  parameter int FRACTION_BITS  = 16,
  parameter int ROTATION_STEPS = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [63:0]  s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [119:0] m_tdata,
  output int                fail_count,
  output int                pending,
  output int                solved_count,
  output int                sat_count,
  output int                range_count
);

  typedef struct packed {
    logic [32:0]      hyp;
    logic [31:0]      leg_b;
    logic [22:0]      alpha;
    logic [22:0]      beta;
    rts_pkg::status_t status;
  } solution_t;

  localparam logic [63:0] RIGHT_ANGLE = 64'd90 << FRACTION_BITS;
  localparam int          ROUND_SHIFT = rts_pkg::ANG_FRAC - FRACTION_BITS;

  logic signed [63:0] step_angle [0:63];
  solution_t          solutions_due [$];

  function automatic logic [63:0] arctan_sum(input logic [63:0] p_in, input logic [63:0] sq);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] d;
    logic        neg;
    p   = p_in;
    sum = '0;
    d   = 64'd1;
    neg = 1'b0;
    while (p != 0) begin
      sum = neg ? sum - p / d : sum + p / d;
      neg = !neg;
      d   = d + 64'd2;
      p   = p / sq;
    end
    return sum;
  endfunction

  function automatic logic [63:0] frac48(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int k = 0; k < rts_pkg::ANG_FRAC; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  initial begin
    logic [63:0] quarter;
    logic [63:0] v;
    quarter = 64'd4 * arctan_sum((64'd1 << 62) / 5, 64'd25)
              - arctan_sum((64'd1 << 62) / 239, 64'd57121);
    step_angle[0] = 64'sd45 <<< rts_pkg::ANG_FRAC;
    for (int i = 1; i < 64; i++) begin
      if (i < 31) v = arctan_sum(64'd1 << (62 - i), 64'd1 << (2 * i));
      else if (i <= 62) v = 64'd1 << (62 - i);
      else v = '0;
      step_angle[i] = $signed(64'd45 * frac48(v, quarter));
    end
  end

  // Rounded square root of u^2 + w^2, radicand up to 66 bits.
  function automatic logic [63:0] length_of(input logic [63:0] u, input logic [63:0] w);
    logic [63:0] u2;
    logic [63:0] lo;
    logic [65:0] rad;
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    u2   = u * u;
    lo   = u2 + w * w;
    rad  = {1'b0, (lo < u2), lo};
    root = '0;
    rem  = '0;
    for (int k = 32; k >= 0; k--) begin
      rem   = (rem << 2) | 64'((rad >> (2 * k)) & 66'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) root++;
    return root;
  endfunction

  function automatic solution_t solve_triangle(input logic angle_given, input logic [63:0] a,
                                               input logic [63:0] second);
    solution_t          s;
    logic [63:0]        c;
    logic [63:0]        b;
    logic [63:0]        alpha;
    logic [63:0]        beta;
    logic [63:0]        m;
    logic [63:0]        ux;
    logic [63:0]        uy;
    logic [63:0]        r;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    int                 sh;
    c = '0; b = '0; alpha = '0; beta = '0;
    s.status = rts_pkg::ST_OK;
    if (!angle_given) begin
      b = second;
      if (a == 0 && b == 0) begin
        s.status = rts_pkg::ST_ZERO;
      end else begin
        c = length_of(a, b);
        if (a == 0) begin
          alpha = '0;
        end else if (b == 0) begin
          alpha = RIGHT_ANGLE;
        end else begin
          // Normalize so the larger leg sits in [2^59, 2^60), then vector to y = 0.
          m  = (a > b) ? a : b;
          sh = 0;
          while (((m << sh) >> 59) == 0) sh++;
          x = $signed(b << sh);
          y = $signed(a << sh);
          z = '0;
          for (int i = 0; i < ROTATION_STEPS && i < 64; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
              x += ys; y -= xs; z += step_angle[i];
            end else begin
              x -= ys; y += xs; z -= step_angle[i];
            end
          end
          if (z < 0) z = '0;
          alpha = (z + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
          if (alpha > RIGHT_ANGLE) alpha = RIGHT_ANGLE;
        end
      end
      beta = RIGHT_ANGLE - alpha;
    end else if (second > RIGHT_ANGLE) begin
      alpha    = RIGHT_ANGLE;
      s.status = rts_pkg::ST_RANGE;
    end else begin
      alpha = second;
      beta  = RIGHT_ANGLE - alpha;
      if (second == 0) begin
        c = rts_pkg::MAX_C; b = rts_pkg::MAX_B; s.status = rts_pkg::ST_SAT;
      end else begin
        x = 64'sd1 <<< 31;
        y = '0;
        z = $signed(second << ROUND_SHIFT);
        for (int i = 0; i < ROTATION_STEPS && i < 64; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (z >= 0) begin
            x -= ys; y += xs; z -= step_angle[i];
          end else begin
            x += ys; y -= xs; z += step_angle[i];
          end
        end
        if (y <= 0) begin
          c = rts_pkg::MAX_C; b = rts_pkg::MAX_B; s.status = rts_pkg::ST_SAT;
        end else begin
          uy = y;
          ux = (x < 0) ? -x : x;
          r  = length_of(ux, uy);
          c  = (a * r + uy / 2) / uy;
          b  = (x <= 0) ? 64'd0 : (a * ux + uy / 2) / uy;
          if (c > rts_pkg::MAX_C) begin
            c = rts_pkg::MAX_C; s.status = rts_pkg::ST_SAT;
          end
          if (b > rts_pkg::MAX_B) begin
            b = rts_pkg::MAX_B; s.status = rts_pkg::ST_SAT;
          end
        end
      end
    end
    s.hyp   = c[32:0];
    s.leg_b = b[31:0];
    s.alpha = alpha[22:0];
    s.beta  = beta[22:0];
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = solutions_due.size();

  always @(posedge clk) begin
    solution_t want;
    solution_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        solutions_due.push_back(solve_triangle(s_tuser, {32'd0, s_tdata[31:0]},
                                               {32'd0, s_tdata[63:32]}));
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[32:0], m_tdata[64:33], m_tdata[87:65], m_tdata[110:88],
               m_tdata[112:111]};
        if (solutions_due.size() == 0) begin
          report_mismatch("result with no request", 64'(m_tdata[63:0]), 64'd0);
        end else begin
          want = solutions_due.pop_front();
          solved_count++;
          if (want.status == rts_pkg::ST_SAT) sat_count++;
          if (want.status == rts_pkg::ST_RANGE) range_count++;
          if (got.hyp !== want.hyp) report_mismatch("hypotenuse", 64'(got.hyp), 64'(want.hyp));
          if (got.leg_b !== want.leg_b)
            report_mismatch("side_b_out", 64'(got.leg_b), 64'(want.leg_b));
          if (got.alpha !== want.alpha)
            report_mismatch("alpha_degrees", 64'(got.alpha), 64'(want.alpha));
          if (got.beta !== want.beta)
            report_mismatch("beta_degrees", 64'(got.beta), 64'(want.beta));
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/right_triangle_solver_tb.sv
// Testbench top for the right triangle solver: stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
`default_nettype none

module right_triangle_solver_tb;

  localparam logic [31:0] RIGHT_ANGLE = 32'd90 << 16;
  localparam int          RANDOM_REQUESTS = 1080;
  localparam int          STALL_LIMIT = 3000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  int           fail_count;
  int           pending;
  int           solved_count;
  int           sat_count;
  int           range_count;
  int           quiet_cycles;
  int           sent_count;

  right_triangle_solver i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  right_triangle_solver_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .solved_count(solved_count),
    .sat_count(sat_count), .range_count(range_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Offer one request and hold it until accepted.
  task automatic send_request(input logic angle_given, input logic [31:0] a,
                              input logic [31:0] second);
    if (!(sent_count >= 300 && sent_count < 500) && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= angle_given;
    s_tdata  <= {second, a};
    do @(posedge clk); while (!s_tready);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] scaled_value();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // Receiver: random stalls, with one long hold-off early on, then a stretch with no stalls.
  initial begin
    int cyc;
    m_tready = 1'b0;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (cyc >= 400 && cyc < 700) m_tready <= 1'b0;
      else if (cyc >= 900 && cyc < 1200) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(99) >= 18);
      cyc++;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL right_triangle_solver");
      $finish;
    end
  end

  initial begin
    logic [31:0] ang;
    sent_count   = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    s_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Legs: zero/zero, one zero, extremes, equal legs.
    send_request(1'b0, 32'd0, 32'd0);
    send_request(1'b0, 32'd0, 32'hFFFF_FFFF);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd0);
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b0, 32'd1, 32'd1);
    send_request(1'b0, 32'd1, 32'hFFFF_FFFF);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd1);
    send_request(1'b0, 32'h0003_0000, 32'h0004_0000);
    send_request(1'b0, 32'd0, 32'd1);
    // Angle given: zero, tiny, 45, 90, just above 90, maximum.
    send_request(1'b1, 32'h0001_0000, 32'd0);
    send_request(1'b1, 32'd0, 32'd0);
    send_request(1'b1, 32'hFFFF_FFFF, 32'd1);
    send_request(1'b1, 32'h0001_0000, 32'h002D_0000);
    send_request(1'b1, 32'hFFFF_FFFF, RIGHT_ANGLE);
    send_request(1'b1, 32'h0001_0000, RIGHT_ANGLE);
    send_request(1'b1, 32'h0001_0000, RIGHT_ANGLE + 1);
    send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd0, 32'h001E_0000);
    send_request(1'b1, 32'hFFFF_FFFF, 32'd100);
    send_request(1'b1, 32'd1, RIGHT_ANGLE - 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: ang = $urandom;
          1: ang = $urandom_range(3);
          2: ang = RIGHT_ANGLE - $urandom_range(3);
          default: ang = $urandom_range(RIGHT_ANGLE);
        endcase
        send_request(1'b1, ($urandom_range(19) == 0) ? 32'd0 : scaled_value(), ang);
      end else begin
        send_request(1'b0, ($urandom_range(19) == 0) ? 32'd0 : scaled_value(),
                     ($urandom_range(19) == 0) ? 32'd0 : scaled_value());
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("covered %0d requests (%0d saturated, %0d angle out of range)",
             solved_count, sat_count, range_count);
    if (fail_count == 0) begin
      $display("PASS right_triangle_solver");
    end else begin
      $display("FAIL right_triangle_solver");
    end
    $finish;
  end

endmodule

`default_nettype wire
